### src/plte_pkg.sv
package plte_pkg;

   localparam int DataWidth = 32;
   localparam int PosWidth = 8;

   typedef enum logic [2:0] {
      ACT_APPEND = 3'd0,
      ACT_READ   = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_SEARCH = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

endpackage

### src/plte_ram.sv
module plte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/positional_list_table_engine.sv
// Ordered list of signed 32-bit values kept in a single-port-write,
// single-port-read RAM of CAPACITY entries, plus an entry count.
// Requests arrive on the req_ stream: append, read, insert, delete,
// search or clear. Each request yields exactly one response on the rsp_
// stream carrying status, found position, read value and the new count.
// One request is worked at a time; req_tready is high only while the
// sequencer is idle, so a new request is not taken until the last response is loaded.
// Work done from acceptance to response valid:
//   append, clear, unused codes and rejected requests: no RAM walk
//   read: one RAM read of the addressed entry
//   insert: entries from the position to the end move one slot up, then the new value is written
//   delete: entries after the position move one slot down
//   search: entries are read from the first until a match or the end of the list
// The RAM has one read and one write port, so each moved or
// compared entry costs one RAM read.
// A finished response sits in an output register; a new request is taken
// while it waits, and the next response is held back until rsp_tready
// frees the register. Reset clears the count, the sequencer state and the handshake state only;
// the RAM contents are not cleared and no clearing pass is run.
module positional_list_table_engine
   import plte_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action [2:0], position [10:3], value [42:11], zero pad [47:43]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [1:0], found_position [9:2], read_value [41:10],
   // entry_count [49:42], zero pad [55:50]
   output logic [55:0] rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int MW = (CW > PosWidth + 1) ? CW : PosWidth + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_WAIT,
      S_INSERT,
      S_DELETE,
      S_SEARCH,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         stop_ff, stop_in;
   logic [AW-1:0]         tag_ff, tag_in;
   logic                  pend_ff, pend_in;
   logic [DataWidth-1:0]  key_ff, key_in;
   status_type            res_status_ff, res_status_in;
   logic [PosWidth-1:0]   res_found_ff, res_found_in;
   logic [DataWidth-1:0]  res_value_ff, res_value_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [PosWidth-1:0]   rsp_found_ff, rsp_found_in;
   logic [DataWidth-1:0]  rsp_value_ff, rsp_value_in;
   logic [PosWidth-1:0]   rsp_count_ff, rsp_count_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DataWidth-1:0]  ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [DataWidth-1:0]  ram_rdata;

   logic [2:0]            req_action;
   logic [DataWidth-1:0]  req_value;
   logic [MW-1:0]         pos_w;
   logic [MW-1:0]         pos_dec;
   logic [MW-1:0]         cnt_w;
   logic                  full;
   logic                  pos_ok;
   logic                  ins_ok;
   logic [CW-1:0]         ptr_dec;
   logic [CW-1:0]         ptr_inc;
   logic [CW-1:0]         tag_next;

   assign req_action = req_tdata[2:0];
   assign req_value  = req_tdata[42:11];
   assign pos_w      = MW'(req_tdata[10:3]);
   assign pos_dec    = pos_w - MW'(1);
   assign cnt_w      = MW'(count_ff);
   assign full       = (count_ff == CW'(CAPACITY));
   assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
   assign ins_ok     = (pos_w != '0) && (pos_w <= cnt_w + MW'(1));
   assign ptr_dec    = ptr_ff - CW'(1);
   assign ptr_inc    = ptr_ff + CW'(1);
   assign tag_next   = CW'(tag_ff) + CW'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_count_ff, rsp_value_ff, rsp_found_ff, rsp_status_ff};

   plte_ram #(
      .WIDTH (DataWidth),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      stop_in       = stop_ff;
      tag_in        = tag_ff;
      pend_in       = pend_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in        = req_value;
               res_status_in = ST_OK;
               res_found_in  = '0;
               res_value_in  = '0;
               pend_in       = 1'b0;
               state_in      = S_FINISH;
               case (action_type'(req_action))
                  ACT_APPEND: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[AW-1:0];
                        ram_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  ACT_READ: begin
                     if (!pos_ok) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        ram_raddr = pos_dec[AW-1:0];
                        state_in  = S_READ_WAIT;
                     end
                  end
                  ACT_INSERT: begin
                     if (!ins_ok) begin
                        res_status_in = ST_RANGE;
                     end else if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ptr_in   = count_ff;
                        stop_in  = CW'(pos_dec);
                        state_in = S_INSERT;
                     end
                  end
                  ACT_DELETE: begin
                     if (!pos_ok) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        ptr_in   = CW'(pos_w);
                        stop_in  = count_ff;
                        state_in = S_DELETE;
                     end
                  end
                  ACT_SEARCH: begin
                     ptr_in   = '0;
                     stop_in  = count_ff;
                     state_in = S_SEARCH;
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            res_value_in = ram_rdata;
            state_in     = S_FINISH;
         end
         S_INSERT: begin
            // Walk downward: each entry read in one cycle is written one slot up
            // in the next, then the new value goes into the opened slot.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = tag_ff;
               ram_wdata = ram_rdata;
            end
            if (ptr_ff != stop_ff) begin
               ram_raddr = ptr_dec[AW-1:0];
               tag_in    = ptr_ff[AW-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_dec;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = stop_ff[AW-1:0];
               ram_wdata = key_ff;
               count_in  = count_ff + CW'(1);
               state_in  = S_FINISH;
            end
         end
         S_DELETE: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = tag_ff;
               ram_wdata = ram_rdata;
            end
            if (ptr_ff != stop_ff) begin
               ram_raddr = ptr_ff[AW-1:0];
               tag_in    = ptr_dec[AW-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_inc;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_FINISH;
            end
         end
         S_SEARCH: begin
            // The tag names the entry whose read data is on the RAM output now.
            if (pend_ff && (ram_rdata == key_ff)) begin
               res_found_in  = PosWidth'(tag_next);
               res_status_in = ST_OK;
               pend_in       = 1'b0;
               state_in      = S_FINISH;
            end else if (ptr_ff != stop_ff) begin
               ram_raddr = ptr_ff[AW-1:0];
               tag_in    = ptr_ff[AW-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_inc;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               res_status_in = ST_MISS;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = PosWidth'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      stop_ff       <= stop_in;
      tag_ff        <= tag_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CW'(ram_waddr) < CW'(CAPACITY)))
      else $error("store write beyond capacity");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_INSERT || state_ff == S_DELETE ||
                   state_ff == S_SEARCH))
      else $error("pending RAM data outside a walk");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && (!rsp_tvalid_ff || rsp_tready))
      |=> (rsp_tvalid_ff && state_ff == S_IDLE))
      else $error("finished response not loaded");
`endif

endmodule

### test/positional_list_table_engine_test.sv
module positional_list_table_engine_test
   import plte_pkg::*;
();

   localparam int ListCapacity = 128;
   localparam int RequestTarget = 1400;
   localparam int CycleLimit = 1000000;
   localparam int TrailingCycles = 140;
   localparam logic [2:0] ActSpareLow = 3'd6;
   localparam logic [2:0] ActSpareHigh = 3'd7;

   typedef struct packed {
      logic [7:0]  entry_count;
      logic [31:0] read_value;
      logic [7:0]  found_position;
      status_type  status;
   } list_response_type;

   // Keeps its own copy of the list and predicts one response per request.
   class list_scoreboard_type;
      logic [31:0] items [ListCapacity];
      int item_count;
      list_response_type expected_q[$];
      int failures;

      function new();
         foreach (items[i]) items[i] = '0;
         item_count = 0;
         failures = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [2:0] act, logic [7:0] pos, logic [31:0] val);
         list_response_type want;
         int p;
         p = pos;
         want = '0;
         want.status = ST_OK;
         case (act)
            ACT_APPEND: begin
               if (item_count >= ListCapacity) begin
                  want.status = ST_FULL;
               end else begin
                  items[item_count] = val;
                  item_count++;
               end
            end
            ACT_READ: begin
               if (p == 0 || p > item_count) want.status = ST_RANGE;
               else want.read_value = items[p - 1];
            end
            ACT_INSERT: begin
               if (p == 0 || p > item_count + 1) begin
                  want.status = ST_RANGE;
               end else if (item_count >= ListCapacity) begin
                  want.status = ST_FULL;
               end else begin
                  for (int i = item_count; i >= p; i--) items[i] = items[i - 1];
                  items[p - 1] = val;
                  item_count++;
               end
            end
            ACT_DELETE: begin
               if (p == 0 || p > item_count) begin
                  want.status = ST_RANGE;
               end else begin
                  for (int i = p - 1; i + 1 < item_count; i++) items[i] = items[i + 1];
                  item_count--;
               end
            end
            ACT_SEARCH: begin
               want.status = ST_MISS;
               for (int i = 0; i < item_count && want.status == ST_MISS; i++) begin
                  if (items[i] == val) begin
                     want.status = ST_OK;
                     want.found_position = 8'(i + 1);
                  end
               end
            end
            ACT_CLEAR: item_count = 0;
            default: ;
         endcase
         want.entry_count = 8'(item_count);
         expected_q.push_back(want);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         failures++;
         if (failures <= 10) $display("mismatch in %s: expected %h, got %h", what, want, got);
      endfunction

      function void check_response(logic [55:0] data);
         list_response_type got, want;
         got = list_response_type'(data[49:0]);
         if (expected_q.size() == 0) begin
            flag("response with no request outstanding", '0, data[31:0]);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) flag("status", want.status, got.status);
         if (got.found_position !== want.found_position)
            flag("found_position", want.found_position, got.found_position);
         if (got.read_value !== want.read_value)
            flag("read_value", want.read_value, got.read_value);
         if (got.entry_count !== want.entry_count)
            flag("entry_count", want.entry_count, got.entry_count);
         if (data[55:50] !== '0) flag("padding", '0, data[55:50]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   list_scoreboard_type board;
   int cycle_count = 0;
   int issued = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;

   positional_list_table_engine #(.CAPACITY(ListCapacity)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("positional_list_table_engine_test NOT OK");
         $finish;
      end
   end

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_request(logic [2:0] act, logic [7:0] pos, logic [31:0] val);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = draw_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, val, pos, act};
      do @(posedge clock); while (!req_tready);
      board.note_request(act, pos, val);
      issued++;
   endtask

   // The last request must be withdrawn, or the idle block would take it again.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 32'($signed($urandom_range(0, 8)) - 4);
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_key();
      if (board.item_count > 0 && $urandom_range(0, 99) < 60)
         return board.items[$urandom_range(0, board.item_count - 1)];
      return pick_value();
   endfunction

   // Mostly a valid 1-based position up to limit, otherwise one out of range.
   function automatic logic [7:0] pick_position(int limit);
      if (limit >= 1 && $urandom_range(0, 99) < 85) return 8'($urandom_range(1, limit));
      case ($urandom_range(0, 2))
         0: return 8'd0;
         1: return 8'(limit + 1);
         default: return 8'($urandom_range(limit + 1, 255));
      endcase
   endfunction

   // Loads the store to capacity and then hits the full and edge positions.
   task automatic fill_store();
      wait_for_drain();
      send_request(ACT_CLEAR, 8'($urandom_range(0, 255)), pick_value());
      while (board.item_count < ListCapacity)
         send_request(ACT_APPEND, 8'($urandom_range(0, 255)), pick_value());
      send_request(ACT_APPEND, 8'd0, pick_value());
      send_request(ACT_INSERT, 8'($urandom_range(1, ListCapacity + 1)), pick_value());
      send_request(ACT_INSERT, 8'(ListCapacity + 2), pick_value());
      send_request(ACT_INSERT, 8'd0, pick_value());
      send_request(ACT_READ, 8'(ListCapacity), pick_value());
      send_request(ACT_READ, 8'(ListCapacity + 1), pick_value());
      send_request(ACT_SEARCH, 8'd0, board.items[ListCapacity - 1]);
      send_request(ACT_DELETE, 8'(ListCapacity), pick_value());
      send_request(ACT_INSERT, 8'(ListCapacity), pick_value());
      send_request(ACT_DELETE, 8'd1, pick_value());
   endtask

   task automatic send_random_request();
      int w, grow;
      grow = (board.item_count > 48) ? 20 : 40;
      w = $urandom_range(0, 99);
      if (w < 3)
         send_request(3'($urandom_range(ActSpareLow, ActSpareHigh)),
                      8'($urandom_range(0, 255)), $urandom);
      else if (w < 5)
         send_request(ACT_CLEAR, 8'($urandom_range(0, 255)), $urandom);
      else if (w < 20)
         send_request(ACT_READ, pick_position(board.item_count), $urandom);
      else if (w < 35)
         send_request(ACT_SEARCH, 8'($urandom_range(0, 255)), pick_key());
      else if (w < 35 + grow / 2)
         send_request(ACT_APPEND, 8'($urandom_range(0, 255)), pick_value());
      else if (w < 35 + grow)
         send_request(ACT_INSERT, pick_position(board.item_count + 1), pick_value());
      else
         send_request(ACT_DELETE, pick_position(board.item_count), $urandom);
   endtask

   initial begin
      int fills;
      board = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty list, edge positions, duplicates, spare codes and clear.
      send_request(ACT_SEARCH, 8'd0, 32'd5);
      send_request(ACT_READ, 8'd1, 32'd0);
      send_request(ACT_DELETE, 8'd1, 32'd0);
      send_request(ACT_INSERT, 8'd0, 32'd1);
      send_request(ACT_INSERT, 8'd2, 32'd1);
      send_request(ACT_INSERT, 8'd1, 32'h7fff_ffff);
      send_request(ACT_APPEND, 8'd255, 32'h8000_0000);
      send_request(ACT_APPEND, 8'd0, 32'h0000_0000);
      send_request(ACT_APPEND, 8'd0, 32'hffff_ffff);
      send_request(ACT_INSERT, 8'd5, 32'h1234_5678);
      send_request(ACT_INSERT, 8'd2, 32'h8000_0000);
      send_request(ACT_READ, 8'd0, 32'd0);
      send_request(ACT_READ, 8'd6, 32'd0);
      send_request(ACT_READ, 8'd7, 32'd0);
      send_request(ACT_SEARCH, 8'd0, 32'h8000_0000);
      send_request(ACT_SEARCH, 8'd0, 32'h5555_5555);
      send_request(ACT_DELETE, 8'd6, 32'd0);
      send_request(ACT_DELETE, 8'd1, 32'd0);
      send_request(ACT_DELETE, 8'd255, 32'd0);
      send_request(ActSpareLow, 8'd255, 32'hffff_ffff);
      send_request(ActSpareHigh, 8'd1, 32'h0000_0000);
      wait_for_drain();
      send_request(ACT_CLEAR, 8'd0, 32'd0);
      send_request(ACT_READ, 8'd1, 32'd0);
      send_request(ACT_SEARCH, 8'd0, 32'hffff_ffff);
      fill_store();
      fills = 1;

      while (issued < RequestTarget) begin
         if (issued >= 500 * fills) begin
            fill_store();
            fills++;
         end else begin
            send_random_request();
         end
      end
      req_tvalid <= 1'b0;

      wait_for_drain();
      repeat (TrailingCycles) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("positional_list_table_engine_test OK");
      end else begin
         $display("positional_list_table_engine_test NOT OK");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         gap = draw_gap(receiver_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_response(rsp_tdata);
      end
   end

endmodule

### files.f
src/plte_pkg.sv
src/plte_ram.sv
src/positional_list_table_engine.sv
test/positional_list_table_engine_test.sv
